// ===== rtl/ecc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and constants of the cross-covariance block
// Operation and register codes, the queued command format and the
// reciprocal constants used by the exp pipeline for exact division by k.
// ----------------------------------------------------------------------------
package ecc_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_WRITE_DISTANCE = 2'd0;
  localparam logic [1:0] OP_WRITE_MAP      = 2'd1;
  localparam logic [1:0] OP_EVALUATE       = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SILL          = 2'd0;
  localparam logic [1:0] REG_NUGGET        = 2'd1;
  localparam logic [1:0] REG_INV_RANGE     = 2'd2;

  // Command queue depth between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // 1.0 in Q1.32.
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // floor(m / k) for m < 2^31 equals (m * DIV_MUL[k]) >> DIV_SHIFT[k],
  // with DIV_SHIFT[k] = 31 + ceil(log2 k) and DIV_MUL[k] = ceil(2^shift / k).
  localparam logic [31:0] DIV_MUL [1:8] = '{
    32'h8000_0000,
    32'h8000_0000,
    32'(((64'd1 << 33) + 64'd2) / 64'd3),
    32'h8000_0000,
    32'(((64'd1 << 34) + 64'd4) / 64'd5),
    32'(((64'd1 << 34) + 64'd5) / 64'd6),
    32'(((64'd1 << 34) + 64'd6) / 64'd7),
    32'h8000_0000
  };
  localparam int DIV_SHIFT [1:8] = '{31, 32, 33, 33, 34, 34, 34, 34};

  // What the back part has to do with one queued command.
  typedef enum logic [1:0] {
    KIND_WRITE_DIST = 2'd0,
    KIND_WRITE_MAP  = 2'd1,
    KIND_EVAL       = 2'd2,
    KIND_ZERO       = 2'd3
  } ecc_kind_e;

  typedef struct packed {
    ecc_kind_e   kind;
    logic [7:0]  loc1;
    logic [7:0]  loc2;
    logic [31:0] data;
  } ecc_cmd_t;

  // Sideband that travels alongside the exp pipeline.
  typedef struct packed {
    logic        use_exp;
    logic [31:0] value;
  } ecc_tag_t;

endpackage

// ===== rtl/exponential_cross_covariance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_cross_covariance: space-time exponential covariance entry
// Loads a distance table and location map, then evaluates one covariance
// entry with nugget per pair of observations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): each transaction is a write of
//   the distance table, a write of the location map, or a pair evaluation.
//   Only evaluations produce a transaction on the output channel
//   (out_valid_o / out_stall_i); unused operation codes and out-of-range
//   writes are taken and dropped.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes sill, nugget
//   and inverse range; it is always ready. The user must use it only while
//   the block idles; the block itself does not enforce this. Throughput is
//   one transaction per cycle while in_stall_o is low. The exp pipeline has
//   eight Horner steps of two stages each plus five squarings, one
//   multiplier per stage, and each table has one read port. If the receiver
//   stalls a waiting result, the back pipeline freezes in place; the
//   four-entry command queue keeps accepting until it fills, then
//   raises in_stall_o. Reset empties the queue and pipeline and loads the
//   default registers; table and map contents stay undefined until written.
// ----------------------------------------------------------------------------
module exponential_cross_covariance #(
  parameter int FIRST_LOCATIONS  = 256,
  parameter int SECOND_LOCATIONS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  first_location_i,
  input  logic [7:0]  second_location_i,
  input  logic [31:0] distance_i,
  input  logic [7:0]  mapped_location_i,
  input  logic [15:0] first_time_i,
  input  logic [15:0] second_time_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] covariance_o,
  // Configuration channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ecc_pkg::*;

  logic [31:0] sill_q;
  logic [31:0] nugget_q;
  logic [31:0] inv_range_q;

  logic        front_keep;
  ecc_cmd_t    front_cmd;
  logic        queue_full;
  logic        queue_valid;
  ecc_cmd_t    queue_cmd;
  logic        back_ready;

  assign cfg_ready_o = 1'b1;

  // Configuration registers. Writes to unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sill_q      <= 32'h0001_0000;
      nugget_q    <= 32'h0000_0000;
      inv_range_q <= 32'h0001_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SILL:      sill_q      <= cfg_data_i;
        REG_NUGGET:    nugget_q    <= cfg_data_i;
        REG_INV_RANGE: inv_range_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front: classify each accepted transaction into a command.
  ecc_front #(
    .FIRST_LOCATIONS  (FIRST_LOCATIONS),
    .SECOND_LOCATIONS (SECOND_LOCATIONS)
  ) u_front (
    .operation_i       (operation_i),
    .first_location_i  (first_location_i),
    .second_location_i (second_location_i),
    .distance_i        (distance_i),
    .mapped_location_i (mapped_location_i),
    .first_time_i      (first_time_i),
    .second_time_i     (second_time_i),
    .keep_o            (front_keep),
    .cmd_o             (front_cmd)
  );

  // The stall depends only on the queue fill level, not on the receiver.
  assign in_stall_o = queue_full;

  ecc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && !in_stall_o && front_keep),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (back_ready),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // Back: memory access, exp pipeline and output register.
  ecc_back #(
    .FIRST_LOCATIONS  (FIRST_LOCATIONS),
    .SECOND_LOCATIONS (SECOND_LOCATIONS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_ready_o  (back_ready),
    .sill_i       (sill_q),
    .nugget_i     (nugget_q),
    .inv_range_i  (inv_range_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .covariance_o (covariance_o)
  );

endmodule

// ===== rtl/ecc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_front: input classifier
// Turns an input transaction into a queued command, or drops it when it
// has no effect.
// ----------------------------------------------------------------------------
module ecc_front #(
  parameter int FIRST_LOCATIONS  = 256,
  parameter int SECOND_LOCATIONS = 256
) (
  input  logic             [1:0]  operation_i,
  input  logic             [7:0]  first_location_i,
  input  logic             [7:0]  second_location_i,
  input  logic             [31:0] distance_i,
  input  logic             [7:0]  mapped_location_i,
  input  logic             [15:0] first_time_i,
  input  logic             [15:0] second_time_i,
  output logic                    keep_o,
  output ecc_pkg::ecc_cmd_t       cmd_o
);
  import ecc_pkg::*;

  logic loc1_ok;
  logic loc2_ok;

  assign loc1_ok = 32'(first_location_i) < 32'(FIRST_LOCATIONS);
  assign loc2_ok = 32'(second_location_i) < 32'(SECOND_LOCATIONS);

  always_comb begin
    cmd_o.kind = KIND_ZERO;
    cmd_o.loc1 = first_location_i;
    cmd_o.loc2 = second_location_i;
    cmd_o.data = distance_i;
    keep_o     = 1'b0;
    case (operation_i)
      OP_WRITE_DISTANCE: begin
        cmd_o.kind = KIND_WRITE_DIST;
        keep_o     = loc1_ok && loc2_ok;
      end
      OP_WRITE_MAP: begin
        cmd_o.kind = KIND_WRITE_MAP;
        cmd_o.data = {24'd0, mapped_location_i};
        keep_o     = loc2_ok;
      end
      OP_EVALUATE: begin
        // Mismatched times and out-of-range locations give a plain zero.
        cmd_o.kind = (loc1_ok && loc2_ok && (first_time_i == second_time_i)) ?
                     KIND_EVAL : KIND_ZERO;
        keep_o     = 1'b1;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/ecc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_fifo: command queue
// Short register queue that decouples the classifier from the back part.
// ----------------------------------------------------------------------------
module ecc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ecc_pkg::ecc_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ecc_pkg::ecc_cmd_t cmd_o
);
  import ecc_pkg::*;

  ecc_cmd_t              entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QUEUE_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QUEUE_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/ecc_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_exp: pipelined exp(-x) evaluator
// Degree-8 Horner series of exp(-x/32) followed by five squarings,
// one multiplication per stage after the entry register; output is Q1.32.
// ----------------------------------------------------------------------------
module ecc_exp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       p_i,
  input  ecc_pkg::ecc_tag_t tag_i,
  output logic              valid_o,
  output logic [32:0]       e_o,
  output ecc_pkg::ecc_tag_t tag_o
);
  import ecc_pkg::*;

  localparam int HornerSteps = 8;
  localparam int Squarings   = 5;
  localparam int NumSt       = 1 + 2 * HornerSteps + Squarings;

  typedef struct packed {
    ecc_tag_t    tag;
    logic        zero;
    logic [30:0] y;
    logic [30:0] m;
    logic [32:0] t;
  } stage_t;

  logic [NumSt-1:0] vld_q;
  stage_t           st_q [NumSt];
  stage_t           st_d [NumSt];

  // Arguments of 16.0 and above give exactly zero.
  always_comb begin
    st_d[0].tag  = tag_i;
    st_d[0].zero = |p_i[63:36];
    st_d[0].y    = p_i[35:5];
    st_d[0].m    = '0;
    st_d[0].t    = ONE_Q32;
  end

  for (genvar i = 0; i < HornerSteps; i++) begin : g_horner
    localparam int K = HornerSteps - i;
    logic [62:0] yt;
    logic [62:0] qk;

    assign yt = 63'(st_q[2*i].y) * 63'(st_q[2*i].t);

    always_comb begin
      st_d[2*i+1]   = st_q[2*i];
      st_d[2*i+1].m = yt[62:32];
    end

    assign qk = 63'(st_q[2*i+1].m) * 63'(DIV_MUL[K]);

    always_comb begin
      st_d[2*i+2]   = st_q[2*i+1];
      st_d[2*i+2].t = ONE_Q32 - 33'(qk >> DIV_SHIFT[K]);
    end
  end

  for (genvar j = 0; j < Squarings; j++) begin : g_square
    localparam int S = 1 + 2 * HornerSteps + j;
    logic [63:0] sq;

    assign sq = 64'(st_q[S-1].t[31:0]) * 64'(st_q[S-1].t[31:0]);

    // A value of exactly 1.0 stays 1.0.
    always_comb begin
      st_d[S] = st_q[S-1];
      if (!st_q[S-1].t[32]) begin
        st_d[S].t = {1'b0, sq[63:32]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vld_q[NumSt-1];
  assign e_o     = st_q[NumSt-1].zero ? '0 : st_q[NumSt-1].t;
  assign tag_o   = st_q[NumSt-1].tag;

endmodule

// ===== rtl/ecc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_back: execution pipeline
// Holds the distance table and location map, performs writes and runs
// evaluations through the exp pipeline into the output register.
// ----------------------------------------------------------------------------
module ecc_back #(
  parameter int FIRST_LOCATIONS  = 256,
  parameter int SECOND_LOCATIONS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ecc_pkg::ecc_cmd_t cmd_i,
  output logic              cmd_ready_o,
  input  logic [31:0]       sill_i,
  input  logic [31:0]       nugget_i,
  input  logic [31:0]       inv_range_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       covariance_o
);
  import ecc_pkg::*;

  localparam int TblDepth = FIRST_LOCATIONS * SECOND_LOCATIONS;
  localparam int TblAw    = (TblDepth > 1) ? $clog2(TblDepth) : 1;
  localparam int MapDepth = (SECOND_LOCATIONS < 256) ? SECOND_LOCATIONS : 256;
  localparam int MapAw    = (MapDepth > 1) ? $clog2(MapDepth) : 1;

  logic              en;
  logic [TblAw-1:0]  tbl_addr;
  logic [MapAw-1:0]  map_addr;

  logic [31:0]       dist_mem_q [TblDepth];
  logic [7:0]        map_mem_q  [MapDepth];

  // Memory access stage.
  logic              r_vld_q;
  ecc_kind_e         r_kind_q;
  logic [7:0]        r_loc1_q;
  logic [31:0]       dist_rd_q;
  logic [7:0]        map_rd_q;

  // Product stage.
  logic              p_vld_q;
  logic [63:0]       p_q;
  ecc_tag_t          p_tag_q, p_tag_d;
  logic [32:0]       colo_sum;

  // Exp pipeline outputs.
  logic              e_vld;
  logic [32:0]       e_val;
  ecc_tag_t          e_tag;

  // Output register.
  logic              out_valid_q;
  logic [31:0]       covariance_q, covariance_d;
  logic [63:0]       scaled;

  // The whole pipeline holds while a finished result waits.
  assign en          = !(out_valid_q && out_stall_i);
  assign cmd_ready_o = en;

  assign tbl_addr = TblAw'(32'(cmd_i.loc1) + 32'(cmd_i.loc2) * 32'(FIRST_LOCATIONS));
  assign map_addr = cmd_i.loc2[MapAw-1:0];

  always_ff @(posedge clk_i) begin
    if (en && cmd_valid_i && (cmd_i.kind == KIND_WRITE_DIST)) begin
      dist_mem_q[tbl_addr] <= cmd_i.data;
    end
    if (en) begin
      dist_rd_q <= dist_mem_q[tbl_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && cmd_valid_i && (cmd_i.kind == KIND_WRITE_MAP)) begin
      map_mem_q[map_addr] <= cmd_i.data[7:0];
    end
    if (en) begin
      map_rd_q <= map_mem_q[map_addr];
    end
  end

  assign colo_sum = {1'b0, sill_i} + {1'b0, nugget_i};

  always_comb begin
    p_tag_d.use_exp = (r_kind_q == KIND_EVAL) && (map_rd_q != r_loc1_q);
    if (r_kind_q == KIND_ZERO) begin
      p_tag_d.value = '0;
    end else begin
      p_tag_d.value = colo_sum[32] ? '1 : colo_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= cmd_valid_i &&
                 ((cmd_i.kind == KIND_EVAL) || (cmd_i.kind == KIND_ZERO));
      p_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_kind_q <= cmd_i.kind;
      r_loc1_q <= cmd_i.loc1;
      p_q      <= 64'(dist_rd_q) * 64'(inv_range_i);
      p_tag_q  <= p_tag_d;
    end
  end

  ecc_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_vld_q),
    .p_i     (p_q),
    .tag_i   (p_tag_q),
    .valid_o (e_vld),
    .e_o     (e_val),
    .tag_o   (e_tag)
  );

  assign scaled = 64'(sill_i) * 64'(e_val[31:0]);

  always_comb begin
    if (!e_tag.use_exp) begin
      covariance_d = e_tag.value;
    end else if (e_val[32]) begin
      covariance_d = sill_i;
    end else begin
      covariance_d = scaled[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= e_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      covariance_q <= covariance_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign covariance_o = covariance_q;

endmodule
